/* hw/rtl/grid_local_maximum_finder_unit_assert.svh */
// Assertion macros for the grid local maximum finder.
// Taken in by the top level with an include; depends on nothing else.
`ifndef GRID_LOCAL_MAXIMUM_FINDER_UNIT_ASSERT_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define GLMF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("grid local maximum finder: invariant violated");

`define GLMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid local maximum finder: implication violated");

`define GLMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid local maximum finder: next-cycle check violated");

`else

`define GLMF_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define GLMF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GLMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/glmf_pkg.sv */
// Package of the grid local maximum finder: field widths, defaults,
// register indexes, the sequencer state type and line-buffer bank helpers.
// Depends on nothing.
`default_nettype none

package glmf_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 32;

    localparam int PIX_W      = 16;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 5;
    localparam int HCFG_W     = 7;
    localparam int WCFG_W     = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_HEIGHT = 1'b0,
        CFG_GRID_WIDTH  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_CMP,
        S_EOF
    } t_state;

    typedef logic [1:0] t_bank;

    // Three line-buffer banks rotate; these step through 0, 1, 2.
    function automatic t_bank bank_next(input t_bank b);
        t_bank res;
        res = (b == 2'd2) ? 2'd0 : b + 2'd1;
        return res;
    endfunction

    function automatic t_bank bank_prev(input t_bank b);
        t_bank res;
        res = (b == 2'd0) ? 2'd2 : b - 2'd1;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/grid_local_maximum_finder_unit.sv */
// Grid local maximum finder: 4-neighbour peaks of a streamed grid of samples.
// Depends on glmf_pkg and on grid_local_maximum_finder_unit_assert.svh.
//
//   channel   direction  handshake                 word
//   pixel     in         i_in_valid / o_in_stall   i_pixel_value
//   peak      out        o_out_valid / i_out_stall o_peak_row, o_peak_col, o_end_of_frame
//   config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A first-row pixel leaves the sequencer idle; any other stalls the input in S_RD0, S_RD1
// and S_CMP, as the single line-buffer memory is read twice for the cell above it before
// the compare. A frame's final pixel also has the last row compared and an end word sent.
// A peak waits in the compare step while the output register is held by a stall.
// Reset is synchronous and clears the counters and the sequencer; the line buffers
// are not cleared.
`default_nettype none

module grid_local_maximum_finder_unit
    import glmf_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [PIX_W-1:0] i_pixel_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [ROW_W-1:0]             o_peak_row,
    output logic [COL_W-1:0]             o_peak_col,
    output logic                         o_end_of_frame,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [AW-1:0] mem_addr(input t_bank b, input logic [CIW-1:0] col);
        logic [AW-1:0] res;
        res = AW'(b) * AW'(MAX_COLS) + AW'(col);
        return res;
    endfunction

    t_state                   r_state, n_state;
    logic [HCFG_W-1:0]        r_grid_height, n_grid_height;
    logic [WCFG_W-1:0]        r_grid_width, n_grid_width;
    logic [RIW-1:0]           r_row_cnt, n_row_cnt;
    logic [CIW-1:0]           r_col_cnt, n_col_cnt;
    t_bank                    r_bank, n_bank;
    logic signed [PIX_W-1:0]  r_px, n_px;
    logic                     r_last, n_last;
    logic                     r_flush, n_flush;
    logic [CIW-1:0]           r_k, n_k;
    logic [RIW-1:0]           r_eval_row, n_eval_row;
    t_bank                    r_mid_bank, n_mid_bank;
    t_bank                    r_up_bank, n_up_bank;
    logic                     r_has_up, n_has_up;
    logic [PIX_W-1:0]         r_self, n_self;
    logic [PIX_W-1:0]         r_up_val, n_up_val;
    logic                     r_out_valid, n_out_valid;
    logic [ROW_W-1:0]         r_out_row, n_out_row;
    logic [COL_W-1:0]         r_out_col, n_out_col;
    logic                     r_out_eof, n_out_eof;

    logic [PIX_W-1:0]         r_mem [DEPTH];
    logic [PIX_W-1:0]         r_rd_a;
    logic [PIX_W-1:0]         r_rd_b;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;

    logic [HW-1:0]            h_eff;
    logic [WW-1:0]            w_eff;
    logic                     pos_wrap;
    logic [RIW-1:0]           pos_r;
    logic [CIW-1:0]           pos_c;
    logic                     last_col;
    logic                     last_row;
    logic                     in_accept;
    logic                     out_free;
    logic                     k_not_last;
    logic                     is_peak;
    logic signed [PIX_W-1:0]  self_s;

    always_comb begin
        if (r_grid_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_grid_height) > 32'(MAX_ROWS)) begin
            h_eff = HW'(MAX_ROWS);
        end else begin
            h_eff = HW'(r_grid_height);
        end
        if (r_grid_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_grid_width) > 32'(MAX_COLS)) begin
            w_eff = WW'(MAX_COLS);
        end else begin
            w_eff = WW'(r_grid_width);
        end
    end

    assign pos_wrap   = (HW'(r_row_cnt) >= h_eff) || (WW'(r_col_cnt) >= w_eff);
    assign pos_r      = pos_wrap ? '0 : r_row_cnt;
    assign pos_c      = pos_wrap ? '0 : r_col_cnt;
    assign last_col   = (WW'(pos_c) + WW'(1)) == w_eff;
    assign last_row   = (HW'(pos_r) + HW'(1)) == h_eff;
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign k_not_last = (WW'(r_k) + WW'(1)) < w_eff;
    assign self_s     = $signed(r_self);

    assign is_peak = !(r_has_up && (self_s < $signed(r_up_val)))
                  && !(!r_flush && (self_s < r_px))
                  && !((r_k != '0) && (self_s < $signed(r_rd_a)))
                  && !(k_not_last && (self_s < $signed(r_rd_b)));

    always_comb begin
        n_state       = r_state;
        n_grid_height = r_grid_height;
        n_grid_width  = r_grid_width;
        n_row_cnt     = r_row_cnt;
        n_col_cnt     = r_col_cnt;
        n_bank        = r_bank;
        n_px          = r_px;
        n_last        = r_last;
        n_flush       = r_flush;
        n_k           = r_k;
        n_eval_row    = r_eval_row;
        n_mid_bank    = r_mid_bank;
        n_up_bank     = r_up_bank;
        n_has_up      = r_has_up;
        n_self        = r_self;
        n_up_val      = r_up_val;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_row     = r_out_row;
        n_out_col     = r_out_col;
        n_out_eof     = r_out_eof;
        wr_en         = 1'b0;
        wr_addr       = mem_addr(r_bank, pos_c);
        rd_en         = 1'b0;
        rd_addr_a     = mem_addr(r_mid_bank, r_k);
        rd_addr_b     = mem_addr(r_up_bank, r_k);

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    wr_en  = 1'b1;
                    n_px   = i_pixel_value;
                    n_last = last_col && last_row;
                    if (!last_col) begin
                        n_row_cnt = pos_r;
                        n_col_cnt = pos_c + CIW'(1);
                    end else if (!last_row) begin
                        n_row_cnt = pos_r + RIW'(1);
                        n_col_cnt = '0;
                        n_bank    = bank_next(r_bank);
                    end else begin
                        n_row_cnt = '0;
                        n_col_cnt = '0;
                    end
                    if (pos_r != '0) begin
                        n_state    = S_RD0;
                        n_flush    = 1'b0;
                        n_k        = pos_c;
                        n_eval_row = pos_r - RIW'(1);
                        n_mid_bank = bank_prev(r_bank);
                        n_up_bank  = bank_prev(bank_prev(r_bank));
                        n_has_up   = pos_r > RIW'(1);
                    end else if (last_col && last_row) begin
                        n_state    = S_RD0;
                        n_flush    = 1'b1;
                        n_k        = '0;
                        n_eval_row = pos_r;
                        n_mid_bank = r_bank;
                        n_up_bank  = bank_prev(r_bank);
                        n_has_up   = 1'b0;
                    end
                end
            end
            S_RD0: begin
                rd_en   = 1'b1;
                n_state = S_RD1;
            end
            S_RD1: begin
                rd_en     = 1'b1;
                n_self    = r_rd_a;
                n_up_val  = r_rd_b;
                rd_addr_a = mem_addr(r_mid_bank, (r_k == '0) ? r_k : r_k - CIW'(1));
                rd_addr_b = mem_addr(r_mid_bank, k_not_last ? r_k + CIW'(1) : r_k);
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (!is_peak || out_free) begin
                    if (is_peak) begin
                        n_out_valid = 1'b1;
                        n_out_row   = ROW_W'(r_eval_row);
                        n_out_col   = COL_W'(r_k);
                        n_out_eof   = 1'b0;
                    end
                    if (!r_flush) begin
                        if (r_last) begin
                            n_state    = S_RD0;
                            n_flush    = 1'b1;
                            n_k        = '0;
                            n_eval_row = r_eval_row + RIW'(1);
                            n_mid_bank = r_bank;
                            n_up_bank  = bank_prev(r_bank);
                            n_has_up   = 1'b1;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else if (k_not_last) begin
                        n_k     = r_k + CIW'(1);
                        n_state = S_RD0;
                    end else begin
                        n_state = S_EOF;
                    end
                end
            end
            S_EOF: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = '0;
                    n_out_col   = '0;
                    n_out_eof   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_HEIGHT: n_grid_height = i_cfg_data;
                CFG_GRID_WIDTH:  n_grid_width  = i_cfg_data[WCFG_W-1:0];
                default: begin
                end
            endcase
            n_row_cnt = '0;
            n_col_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_height <= HCFG_W'(1);
            r_grid_width  <= WCFG_W'(1);
            r_row_cnt     <= '0;
            r_col_cnt     <= '0;
            r_bank        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_grid_height <= n_grid_height;
            r_grid_width  <= n_grid_width;
            r_row_cnt     <= n_row_cnt;
            r_col_cnt     <= n_col_cnt;
            r_bank        <= n_bank;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_last     <= n_last;
        r_flush    <= n_flush;
        r_k        <= n_k;
        r_eval_row <= n_eval_row;
        r_mid_bank <= n_mid_bank;
        r_up_bank  <= n_up_bank;
        r_has_up   <= n_has_up;
        r_self     <= n_self;
        r_up_val   <= n_up_val;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_eof  <= n_out_eof;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    assign o_in_stall     = r_state != S_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_peak_row     = r_out_row;
    assign o_peak_col     = r_out_col;
    assign o_end_of_frame = r_out_eof;

`include "grid_local_maximum_finder_unit_assert.svh"

    `GLMF_ASSERT_ALWAYS(a_col_in_range, i_clk, i_rst_n, WW'(r_col_cnt) < w_eff)
    `GLMF_ASSERT_ALWAYS(a_row_in_range, i_clk, i_rst_n, HW'(r_row_cnt) < h_eff)
    `GLMF_ASSERT_NEXT(a_eof_restarts, i_clk, i_rst_n, (r_state == S_EOF) && out_free, (r_row_cnt == '0) && (r_col_cnt == '0))
    `GLMF_ASSERT_IMPL(a_eof_word_zero, i_clk, i_rst_n, o_out_valid && o_end_of_frame, (o_peak_row == '0) && (o_peak_col == '0))

endmodule

`default_nettype wire
